/* src/sha256_stream_hasher_macros.svh */
// assertion macros for the sha256 stream hasher
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SHA_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT(label, clk, rst_n, prop)
`define SHA_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* src/sha_pkg.sv */
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenOffset = 56;
  localparam int unsigned NumRounds = 64;
  localparam logic [7:0] PadMark = 8'h80;

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StLen,
    StRound,
    StUpdate,
    StEmit
  } state_e;

  typedef enum logic [1:0] {
    FillNone,
    FillData,
    FillZero,
    FillLen
  } fill_e;

  typedef struct packed {
    fill_e      fill;
    logic [5:0] fill_addr;
    logic [7:0] fill_byte;
    logic       load_work;
    logic       do_round;
    logic       update_hash;
    logic       init_hash;
    logic       count_inc;
    logic       count_clr;
    logic [2:0] out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] offset;
  } dp_stat_t;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

/* src/sha256_stream_hasher.sv */
// Streaming SHA-256. Each accepted word is a message byte (kind 0) or a finish
// command (kind 1). Bytes go in one per cycle while idle; the 64th byte of a
// block starts compression (load, 64 rounds in one shared round unit, update),
// during which no word is accepted. Finish writes the padding one byte per
// cycle, compresses one or two blocks, then presents eight digest words, H0
// first with word_last on the eighth, and returns to the initial hash state.
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic        word_last_o
);
  import sha_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [5:0] round;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .data_byte_i,
    .out_valid_o, .out_ready_i, .word_last_o,
    .stat_i(stat), .cmd_o(cmd), .round_o(round)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .round_i(round), .stat_o(stat), .digest_word_o
  );

endmodule

/* src/sha_datapath.sv */
module sha_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha_pkg::dp_cmd_t  cmd_i,
  input  logic [5:0]        round_i,
  output sha_pkg::dp_stat_t stat_o,
  output logic [31:0]       digest_word_o
);
  import sha_pkg::*;

  logic [511:0] block_q;
  logic [255:0] hash_q, hash_d;
  logic [31:0]  work_q [8];
  logic [31:0]  win_q [16];
  logic [60:0]  count_q;
  logic [63:0]  bits;
  logic [31:0]  w15, w2, g0, g1, wnew, wt, s0, s1, ch, maj, t1, t2;
  logic [31:0]  a, e;

  assign bits = {count_q, 3'b000};

  always_ff @(posedge clk_i) begin
    case (cmd_i.fill)
      FillData: block_q[511 - 8 * cmd_i.fill_addr -: 8] <= cmd_i.fill_byte;
      FillZero: block_q[511 - 8 * cmd_i.fill_addr -: 8] <= 8'h00;
      FillLen:  block_q[63:0] <= bits;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.count_clr) begin
      count_q <= '0;
    end else if (cmd_i.count_inc) begin
      count_q <= count_q + 61'd1;
    end
  end

  assign stat_o.offset = count_q[5:0];

  assign a   = work_q[0];
  assign e   = work_q[4];
  assign w15 = win_q[1];
  assign w2  = win_q[14];
  assign g0  = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
  assign g1  = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
  assign wnew = win_q[0] + g0 + win_q[9] + g1;
  assign wt  = (round_i < 6'd16) ? win_q[0] : wnew;
  assign s0  = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign s1  = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign ch  = (e & work_q[5]) ^ (~e & work_q[6]);
  assign maj = (a & work_q[1]) ^ (a & work_q[2]) ^ (work_q[1] & work_q[2]);
  assign t1  = work_q[7] + s1 + ch + round_k(round_i) + wt;
  assign t2  = s0 + maj;

  // window shifts each round, oldest word at index 0
  // the length words go straight into the window when they are written on load
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_work) begin
      for (int i = 0; i < 8; i++) work_q[i] <= hash_q[255 - 32 * i -: 32];
      for (int i = 0; i < 14; i++) win_q[i] <= block_q[511 - 32 * i -: 32];
      win_q[14] <= (cmd_i.fill == FillLen) ? bits[63:32] : block_q[63:32];
      win_q[15] <= (cmd_i.fill == FillLen) ? bits[31:0] : block_q[31:0];
    end else if (cmd_i.do_round) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
      win_q[15] <= wt;
      work_q[7] <= work_q[6];
      work_q[6] <= work_q[5];
      work_q[5] <= work_q[4];
      work_q[4] <= work_q[3] + t1;
      work_q[3] <= work_q[2];
      work_q[2] <= work_q[1];
      work_q[1] <= work_q[0];
      work_q[0] <= t1 + t2;
    end
  end

  always_comb begin
    hash_d = hash_q;
    if (cmd_i.init_hash) begin
      hash_d = InitHash;
    end else if (cmd_i.update_hash) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[255 - 32 * i -: 32] = hash_q[255 - 32 * i -: 32] + work_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= InitHash;
    end else begin
      hash_q <= hash_d;
    end
  end

  assign digest_word_o = hash_q[255 - 32 * cmd_i.out_sel -: 32];

endmodule

/* src/sha_ctrl.sv */
`include "sha256_stream_hasher_macros.svh"
module sha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [7:0]        data_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              word_last_o,
  input  sha_pkg::dp_stat_t stat_i,
  output sha_pkg::dp_cmd_t  cmd_o,
  output logic [5:0]        round_o
);
  import sha_pkg::*;

  state_e     state_q, state_d;
  logic [5:0] round_q, round_d;
  logic [5:0] pad_q, pad_d;
  logic [2:0] oidx_q, oidx_d;
  logic       fin_q, fin_d;
  logic       two_q, two_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      round_q <= '0;
      pad_q   <= '0;
      oidx_q  <= '0;
      fin_q   <= 1'b0;
      two_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      pad_q   <= pad_d;
      oidx_q  <= oidx_d;
      fin_q   <= fin_d;
      two_q   <= two_d;
    end
  end

  assign round_o = round_q;

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    pad_d   = pad_q;
    oidx_d  = oidx_q;
    fin_d   = fin_q;
    two_d   = two_q;
    cmd_o   = '0;
    cmd_o.fill = FillNone;
    cmd_o.fill_addr = stat_i.offset;
    cmd_o.fill_byte = data_byte_i;
    cmd_o.out_sel = oidx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    word_last_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.fill = FillData;
          if (!kind_i) begin
            cmd_o.count_inc = 1'b1;
            if (stat_i.offset == 6'(BlockBytes - 1)) begin
              fin_d = 1'b0;
              state_d = StLen;
            end
          end else begin
            cmd_o.fill_byte = PadMark;
            fin_d = 1'b1;
            two_d = (stat_i.offset >= 6'(LenOffset));
            pad_d = stat_i.offset + 6'd1;
            state_d = (stat_i.offset == 6'(BlockBytes - 1)) ? StLen : StPad;
          end
        end
      end
      StPad: begin
        cmd_o.fill = FillZero;
        cmd_o.fill_addr = pad_q;
        pad_d = pad_q + 6'd1;
        if (pad_q == 6'(BlockBytes - 1)) state_d = StLen;
      end
      StLen: begin
        if (fin_q && !two_q) cmd_o.fill = FillLen;
        cmd_o.load_work = 1'b1;
        round_d = '0;
        state_d = StRound;
      end
      StRound: begin
        cmd_o.do_round = 1'b1;
        round_d = round_q + 6'd1;
        if (round_q == 6'(NumRounds - 1)) state_d = StUpdate;
      end
      StUpdate: begin
        cmd_o.update_hash = 1'b1;
        if (!fin_q) begin
          state_d = StIdle;
        end else if (two_q) begin
          two_d = 1'b0;
          pad_d = '0;
          state_d = StPad;
        end else begin
          oidx_d = '0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        out_valid_o = 1'b1;
        word_last_o = (oidx_q == 3'd7);
        if (out_ready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            cmd_o.init_hash = 1'b1;
            cmd_o.count_clr = 1'b1;
            fin_d = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  `SHA_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != StIdle) |-> !in_ready_o)
  `SHA_ASSERT(a_round_wrap, clk_i, rst_ni, (state_q == StUpdate) |-> (round_q == 6'd0))
  `SHA_ASSERT_NEVER(a_emit_only_fin, clk_i, rst_ni, out_valid_o && !fin_q)
  `SHA_ASSERT(a_last_home, clk_i, rst_ni, (out_valid_o && out_ready_i && word_last_o) |=> (state_q == StIdle))

endmodule
